FILE: design/mbsp_pkg.sv
// Package for the MIDI byte stream parser: constants, code types and result struct.
// Has no dependencies; the core, the output stage, the top unit and the test files use it.
package mbsp_pkg;

   localparam int PORTS = 16;
   localparam logic [4:0] PORT_LIMIT = 5'(PORTS);

   localparam logic [3:0] TYPE_NONE = 4'h0;
   localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
   localparam logic [3:0] TYPE_NOTE_ON = 4'h9;
   localparam logic [3:0] TYPE_SYSTEM = 4'hF;

   typedef enum logic [2:0] {
      SYS_SYSEX = 3'd0,
      SYS_TIME_CODE = 3'd1,
      SYS_SONG_POSITION = 3'd2,
      SYS_SONG_SELECT = 3'd3,
      SYS_UNDEFINED_4 = 3'd4,
      SYS_UNDEFINED_5 = 3'd5,
      SYS_TUNE_REQUEST = 3'd6,
      SYS_END_EXCLUSIVE = 3'd7
   } sys_code_type;

   typedef struct packed {
      logic [3:0] msg_type;
      logic [7:0] channel;
      logic [6:0] data_one;
      logic [6:0] data_two;
      logic       is_note;
   } result_type;

   // Number of data bytes for a channel message, indexed by the low three
   // bits of its type nibble.
   function automatic logic [1:0] data_count(input logic [2:0] type_low);
      logic [1:0] count;
      case (type_low)
         3'd4, 3'd5: count = 2'd1;
         3'd7:       count = 2'd0;
         default:    count = 2'd2;
      endcase
      return count;
   endfunction

endpackage

FILE: design/mbsp_if.sv
// Valid/ready channel interfaces for the byte input and the message output.
// Depends on no other file; the result field widths are written out here.
interface mbsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface mbsp_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] msg_type;
   logic [7:0] channel;
   logic [6:0] data_one;
   logic [6:0] data_two;
   logic       is_note;

   modport source (output valid, output msg_type, output channel, output data_one,
                   output data_two, output is_note, input ready);
   modport sink (input valid, input msg_type, input channel, input data_one,
                 input data_two, input is_note, output ready);
endinterface

FILE: design/midi_byte_stream_parser_unit.sv
// MIDI byte stream parser with running status: one byte in, at most one message out.
// An accepted byte passes the input register and the core into the output register.
// Throughput is one byte per cycle while the output stage has space for a message.
// Synchronous reset clears the parser state and both stage valid flags.
// Depends on mbsp_pkg, mbsp_if and the input, core and output stage modules.
module midi_byte_stream_parser_unit (
   input  logic      clock,
   input  logic      reset,
   mbsp_req_if.sink  req,
   mbsp_rsp_if.source rsp
);

   logic                 byte_valid;
   logic [7:0]           byte_value;
   logic                 advance;
   logic                 space;
   logic                 result_valid;
   mbsp_pkg::result_type result;

   assign advance = byte_valid && space;

   mbsp_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .advance    (advance),
      .byte_valid (byte_valid),
      .byte_value (byte_value)
   );

   mbsp_parser_core u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .byte_value   (byte_value),
      .result_valid (result_valid),
      .result       (result)
   );

   mbsp_output_stage u_output (
      .clock  (clock),
      .reset  (reset),
      .load   (advance && result_valid),
      .result (result),
      .space  (space),
      .rsp    (rsp)
   );

endmodule

FILE: design/mbsp_input_stage.sv
// Input register that holds one accepted byte until the parser core takes it.
// Depends on mbsp_if.
module mbsp_input_stage (
   input  logic       clock,
   input  logic       reset,
   mbsp_req_if.sink   req,
   input  logic       advance,
   output logic       byte_valid,
   output logic [7:0] byte_value
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   assign req.ready = !valid_ff || advance;
   assign valid_in = (req.valid && req.ready) ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         byte_ff <= req.in_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_value = byte_ff;

endmodule

FILE: design/mbsp_parser_core.sv
// Running status parser: holds the message state and decodes one byte per cycle while advance is high.
// Depends on mbsp_pkg.
module mbsp_parser_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          byte_value,
   output logic                result_valid,
   output mbsp_pkg::result_type result
);

   logic [3:0] type_ff, type_in;
   logic [7:0] channel_ff, channel_in;
   logic [6:0] first_ff, first_in;
   logic [6:0] second_ff, second_in;
   logic [1:0] seen_ff, seen_in;
   logic [1:0] needed_ff, needed_in;
   logic       sysex_ff, sysex_in;
   logic       discard_ff, discard_in;
   logic       port_ff, port_in;
   logic [1:0] seen_next;
   mbsp_pkg::sys_code_type sys_code;

   always_comb begin
      type_in = type_ff;
      channel_in = channel_ff;
      first_in = first_ff;
      second_in = second_ff;
      seen_in = seen_ff;
      needed_in = needed_ff;
      sysex_in = sysex_ff;
      discard_in = discard_ff;
      port_in = port_ff;
      result_valid = 1'b0;
      seen_next = 2'(seen_ff + 2'd1);
      sys_code = mbsp_pkg::sys_code_type'(byte_value[2:0]);
      result.msg_type = type_ff;
      result.channel = channel_ff;
      result.data_one = first_ff;
      result.data_two = 7'd0;
      result.is_note = (type_ff == mbsp_pkg::TYPE_NOTE_OFF) ||
                       (type_ff == mbsp_pkg::TYPE_NOTE_ON);

      if (byte_value[7]) begin
         if (port_ff) begin
            // A status byte right after a channel status names the port.
            port_in = 1'b0;
            if ({1'b0, byte_value[3:0]} < mbsp_pkg::PORT_LIMIT) begin
               channel_in = 8'(channel_ff + {byte_value[3:0], 4'd0});
            end
         end else if (byte_value[7:4] == mbsp_pkg::TYPE_SYSTEM) begin
            if (!byte_value[3]) begin
               sysex_in = 1'b0;
               unique case (sys_code)
                  mbsp_pkg::SYS_SYSEX: begin
                     sysex_in = 1'b1;
                  end
                  mbsp_pkg::SYS_TIME_CODE, mbsp_pkg::SYS_SONG_SELECT,
                  mbsp_pkg::SYS_SONG_POSITION: begin
                     type_in = mbsp_pkg::TYPE_SYSTEM;
                     channel_in = {5'd0, byte_value[2:0]};
                     needed_in = (sys_code == mbsp_pkg::SYS_SONG_POSITION) ? 2'd2 : 2'd1;
                     seen_in = 2'd0;
                     discard_in = 1'b0;
                  end
                  mbsp_pkg::SYS_UNDEFINED_4, mbsp_pkg::SYS_UNDEFINED_5: begin
                     discard_in = 1'b1;
                     seen_in = 2'd0;
                  end
                  default: begin
                  end
               endcase
            end
         end else begin
            sysex_in = 1'b0;
            discard_in = 1'b0;
            type_in = byte_value[7:4];
            channel_in = {4'd0, byte_value[3:0]};
            needed_in = mbsp_pkg::data_count(byte_value[6:4]);
            seen_in = 2'd0;
            port_in = 1'b1;
         end
      end else begin
         port_in = 1'b0;
         if (!sysex_ff && !discard_ff && (type_ff != mbsp_pkg::TYPE_NONE)) begin
            if (seen_ff == 2'd0) begin
               first_in = byte_value[6:0];
            end else begin
               second_in = byte_value[6:0];
            end
            if (seen_next < needed_ff) begin
               seen_in = seen_next;
            end else begin
               seen_in = 2'd0;
               result_valid = 1'b1;
               result.data_one = (seen_ff == 2'd0) ? byte_value[6:0] : first_ff;
               result.data_two = (needed_ff < 2'd2) ? 7'd0 :
                                 ((seen_ff == 2'd0) ? second_ff : byte_value[6:0]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff <= mbsp_pkg::TYPE_NONE;
         channel_ff <= 8'd0;
         first_ff <= 7'd0;
         second_ff <= 7'd0;
         seen_ff <= 2'd0;
         needed_ff <= 2'd0;
         sysex_ff <= 1'b0;
         discard_ff <= 1'b0;
         port_ff <= 1'b0;
      end else if (advance) begin
         type_ff <= type_in;
         channel_ff <= channel_in;
         first_ff <= first_in;
         second_ff <= second_in;
         seen_ff <= seen_in;
         needed_ff <= needed_in;
         sysex_ff <= sysex_in;
         discard_ff <= discard_in;
         port_ff <= port_in;
      end
   end

endmodule

FILE: design/mbsp_output_stage.sv
// Result register that holds one message until the output channel takes it.
// Depends on mbsp_pkg and mbsp_if.
module mbsp_output_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  mbsp_pkg::result_type result,
   output logic                space,
   mbsp_rsp_if.source          rsp
);

   logic                 valid_ff, valid_in;
   mbsp_pkg::result_type result_ff;

   assign space = !valid_ff || rsp.ready;
   assign valid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp.valid = valid_ff;
   assign rsp.msg_type = result_ff.msg_type;
   assign rsp.channel = result_ff.channel;
   assign rsp.data_one = result_ff.data_one;
   assign rsp.data_two = result_ff.data_two;
   assign rsp.is_note = result_ff.is_note;

endmodule

FILE: test/midi_check_pkg.sv
// Message tracker for the MIDI byte stream parser testbench: predicts messages from accepted
// bytes and checks the messages that the block emits.
// Depends on mbsp_pkg for the result struct, type codes and system codes.
package midi_check_pkg;
   import mbsp_pkg::*;

   class midi_msg_tracker;
      logic [3:0] run_type;
      logic [7:0] run_chan;
      logic [6:0] first_byte;
      logic [6:0] second_byte;
      logic [1:0] seen_count;
      logic [1:0] need_count;
      bit         sysex_skip;
      bit         discard_data;
      bit         port_open;
      result_type expected_msgs[$];
      int         msg_index;
      int         failures;

      function new();
         run_type = TYPE_NONE;
         run_chan = '0;
         first_byte = '0;
         second_byte = '0;
         seen_count = '0;
         need_count = '0;
         sysex_skip = 0;
         discard_data = 0;
         port_open = 0;
         msg_index = 0;
         failures = 0;
      endfunction

      function int pending_count();
         return expected_msgs.size();
      endfunction

      function void start_system(logic [2:0] code, logic [1:0] need);
         run_type = TYPE_SYSTEM;
         run_chan = {5'd0, code};
         need_count = need;
         seen_count = '0;
         discard_data = 0;
      endfunction

      // Updates the parser state for one accepted beat and queues any completed message.
      function void note_byte(logic [7:0] b);
         result_type msg;
         if (b[7]) begin
            if (port_open) begin
               port_open = 0;
               if ({1'b0, b[3:0]} < PORT_LIMIT) begin
                  run_chan = run_chan + {b[3:0], 4'h0};
               end
               return;
            end
            if (b[7:4] == TYPE_SYSTEM) begin
               if (b[3]) begin
                  return;
               end
               sysex_skip = 0;
               case (sys_code_type'(b[2:0]))
                  SYS_SYSEX: begin
                     sysex_skip = 1;
                  end
                  SYS_TIME_CODE, SYS_SONG_SELECT: begin
                     start_system(b[2:0], 2'd1);
                  end
                  SYS_SONG_POSITION: begin
                     start_system(b[2:0], 2'd2);
                  end
                  SYS_UNDEFINED_4, SYS_UNDEFINED_5: begin
                     discard_data = 1;
                     seen_count = '0;
                  end
                  default: begin
                  end
               endcase
               return;
            end
            sysex_skip = 0;
            discard_data = 0;
            run_type = b[7:4];
            run_chan = {4'h0, b[3:0]};
            case (b[6:4])
               3'd4, 3'd5: need_count = 2'd1;
               3'd7:       need_count = 2'd0;
               default:    need_count = 2'd2;
            endcase
            seen_count = '0;
            port_open = 1;
            return;
         end
         port_open = 0;
         if (sysex_skip || discard_data || run_type == TYPE_NONE) begin
            return;
         end
         if (seen_count == 2'd0) begin
            first_byte = b[6:0];
         end else begin
            second_byte = b[6:0];
         end
         seen_count = seen_count + 2'd1;
         if (seen_count < need_count) begin
            return;
         end
         seen_count = '0;
         msg.msg_type = run_type;
         msg.channel = run_chan;
         msg.data_one = first_byte;
         msg.data_two = (need_count < 2'd2) ? 7'd0 : second_byte;
         msg.is_note = (run_type == TYPE_NOTE_OFF || run_type == TYPE_NOTE_ON);
         expected_msgs.push_back(msg);
      endfunction

      function void report(string what, result_type exp, result_type got);
         failures++;
         if (failures <= 10) begin
            $display("message %0d %s: expected type %h ch %h d1 %h d2 %h note %b, ",
                     msg_index, what, exp.msg_type, exp.channel, exp.data_one,
                     exp.data_two, exp.is_note,
                     "got type %h ch %h d1 %h d2 %h note %b",
                     got.msg_type, got.channel, got.data_one, got.data_two,
                     got.is_note);
         end
      endfunction

      function void check_result(result_type got);
         result_type exp;
         if (expected_msgs.size() == 0) begin
            report("unexpected", '0, got);
         end else begin
            exp = expected_msgs.pop_front();
            if (got.msg_type !== exp.msg_type || got.channel !== exp.channel ||
                got.data_one !== exp.data_one || got.data_two !== exp.data_two ||
                got.is_note !== exp.is_note) begin
               report("mismatch", exp, got);
            end
         end
         msg_index++;
      endfunction

      function void final_check();
         if (expected_msgs.size() != 0) begin
            failures++;
            $display("%0d expected messages never arrived", expected_msgs.size());
         end
      endfunction
   endclass

endpackage

FILE: test/tb_midi_byte_stream_parser_unit.sv
// Top-level testbench for the MIDI byte stream parser: directed and random byte streams with
// random stalls on both channels, every message checked against the tracker's prediction.
// Depends on mbsp_pkg, mbsp_if, midi_check_pkg and the parser unit.
module tb_midi_byte_stream_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import mbsp_pkg::*;
   import midi_check_pkg::*;

   logic clock;
   logic reset;
   int   bytes_sent;
   int   bytes_accepted;
   int   cycle_count;
   bit   sender_quiet;
   midi_msg_tracker tracker;

   mbsp_req_if req_ch();
   mbsp_rsp_if rsp_ch();

   midi_byte_stream_parser_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      result_type got;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.msg_type = rsp_ch.msg_type;
            got.channel = rsp_ch.channel;
            got.data_one = rsp_ch.data_one;
            got.data_two = rsp_ch.data_two;
            got.is_note = rsp_ch.is_note;
            tracker.check_result(got);
         end
         if (req_ch.valid && req_ch.ready) begin
            tracker.note_byte(req_ch.in_byte);
            bytes_accepted <= bytes_accepted + 1;
         end
      end
   end

   // Receiver: random stalls, quiet stretches, and one long hold-off once traffic is flowing.
   initial begin
      int  stall_left;
      bit  long_hold_done;
      stall_left = 0;
      long_hold_done = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && bytes_accepted >= 300) begin
            long_hold_done = 1;
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
            @(posedge clock);
         end else if (cycle_count[8:7] != 2'b00 && $urandom_range(0, 99) < 25) begin
            stall_left = gap_length();
            rsp_ch.ready <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = sender_quiet ? 0 : gap_length();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.in_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_count() != 0) @(posedge clock);
   endtask

   task automatic send_data_run(input int count);
      repeat (count) begin
         if ($urandom_range(0, 99) < 8) send_byte(8'hF8 | 8'($urandom_range(0, 7)));
         send_byte(8'($urandom_range(0, 127)));
      end
   endtask

   task automatic send_random_phrase();
      int         kind;
      int         need;
      logic [7:0] status;
      kind = $urandom_range(0, 99);
      sender_quiet = ($urandom_range(0, 99) < 15);
      if (kind < 45) begin
         status = 8'h80 + 8'($urandom_range(0, 8'h6F));
         send_byte(status);
         if ($urandom_range(0, 99) < 30) send_byte(8'h80 | 8'($urandom_range(0, 127)));
         need = (status[6:4] == 3'd4 || status[6:4] == 3'd5) ? 1 : 2;
         send_data_run(need * $urandom_range(1, 4) - (($urandom_range(0, 9) == 0) ? 1 : 0));
      end else if (kind < 60) begin
         status = 8'hF0 | 8'($urandom_range(1, 3));
         send_byte(status);
         need = (status[2:0] == SYS_SONG_POSITION) ? 2 : 1;
         send_data_run(need * $urandom_range(1, 3));
      end else if (kind < 70) begin
         send_byte(8'hF0);
         send_data_run($urandom_range(0, 6));
         if ($urandom_range(0, 1)) send_byte(8'hF7);
      end else if (kind < 78) begin
         send_byte($urandom_range(0, 1) ? 8'hF4 : 8'hF5);
         send_data_run($urandom_range(0, 4));
         if ($urandom_range(0, 1)) send_byte($urandom_range(0, 1) ? 8'hF6 : 8'hF7);
      end else if (kind < 85) begin
         send_byte(8'hF8 | 8'($urandom_range(0, 7)));
      end else begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      static logic [7:0] directed_bytes[] = '{
         8'h40,
         8'h90, 8'h00, 8'h7F, 8'h3C,
         8'h8F, 8'hF3, 8'h7F, 8'h00,
         8'hC5, 8'h10,
         8'hE0, 8'h55, 8'hF8, 8'h2A,
         8'hF0, 8'h11, 8'hF7,
         8'hF1, 8'h05,
         8'hF2, 8'h7F, 8'h7F,
         8'hF4, 8'h01, 8'hF6, 8'h02,
         8'hD7, 8'hFF, 8'h40,
         8'hA1, 8'h10, 8'hF6, 8'h20
      };
      tracker = new();
      bytes_sent = 0;
      bytes_accepted = 0;
      cycle_count = 0;
      sender_quiet = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.in_byte <= 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      wait_for_drain();

      while (bytes_sent < 600) send_random_phrase();
      wait_for_drain();
      while (bytes_sent < 1050) send_random_phrase();
      wait_for_drain();
      repeat (8) @(posedge clock);

      tracker.final_check();
      if (tracker.failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
